// ----- rtl/core/uqts_pkg.sv -----
package uqts_pkg;

  localparam int unsigned TOKEN_LENGTH_MAX = 4095;
  localparam int unsigned LenW = $clog2(TOKEN_LENGTH_MAX + 1);
  localparam int unsigned TokLenW = 12;

  localparam logic [7:0] CharNul     = 8'h00;
  localparam logic [7:0] CharLf      = 8'h0a;
  localparam logic [7:0] CharCr      = 8'h0d;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharAmp     = 8'h26;
  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharEquals  = 8'h3d;
  localparam logic [7:0] CharQuery   = 8'h3f;

  typedef enum logic [1:0] {
    ModePath  = 2'd0,
    ModeParam = 2'd1,
    ModeValue = 2'd2,
    ModeSkip  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StMalformed = 2'd1,
    StEmpty     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    EscNone = 2'd0,
    EscHigh = 2'd1,
    EscLow  = 2'd2
  } esc_e;

  typedef struct packed {
    logic [7:0] in_byte;
    mode_e      mode;
  } in_t;

  typedef struct packed {
    logic               char_valid;
    logic [7:0]         out_char;
    logic               token_end;
    logic [1:0]         status;
    logic [TokLenW-1:0] token_length;
    logic               reconsume;
  } out_t;

  typedef struct packed {
    esc_e            esc;
    logic [3:0]      high_nibble;
    logic [LenW-1:0] length_count;
  } state_t;

  // Bit 0 continues a path, bit 1 a parameter, bit 2 a value; bit 3 is a hard terminator.
  localparam logic [3:0] ClassLo [128] = '{
    4'd8, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd0, 4'd0, 4'd8, 4'd0, 4'd0, 4'd8, 4'd0, 4'd0,
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd8, 4'd7, 4'd8, 4'd8, 4'd8, 4'd7, 4'd0, 4'd7,
    4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
    4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
    4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd4, 4'd7, 4'd6,
    4'd4, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
    4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
    4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
    4'd7, 4'd7, 4'd7, 4'd8, 4'd8, 4'd8, 4'd8, 4'd7,
    4'd8, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
    4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
    4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
    4'd7, 4'd7, 4'd7, 4'd8, 4'd8, 4'd8, 4'd7, 4'd0
  };

  function automatic logic [3:0] byte_class(input logic [7:0] b);
    logic [3:0] cls;
    cls = b[7] ? 4'd0 : ClassLo[b[6:0]];
    return cls;
  endfunction

  // Bit 4 of the result flags a byte that is no hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = {1'b0, b[3:0]};
    end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      v = {1'b0, b[3:0] + 4'd9};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

endpackage

// ----- rtl/core/uqts_step.sv -----
module uqts_step import uqts_pkg::*; (
  input  state_t st_i,
  input  in_t    item_i,
  output logic   res_valid_o,
  output out_t   res_o,
  output state_t st_next_o
);

  logic [3:0]      cls;
  logic [4:0]      hv;
  logic [7:0]      b;
  logic [LenW-1:0] len_inc;
  logic            end_tok;
  status_e         e_status;
  logic [LenW-1:0] e_len;
  logic            e_again;

  assign b       = item_i.in_byte;
  assign cls     = byte_class(b);
  assign hv      = hex_value(b);
  assign len_inc = (st_i.length_count < LenW'(TOKEN_LENGTH_MAX)) ?
                   st_i.length_count + LenW'(1) : st_i.length_count;

  always_comb begin
    st_next_o   = st_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    end_tok     = 1'b0;
    e_status    = StOk;
    e_len       = st_i.length_count;
    e_again     = 1'b0;

    if (st_i.esc == EscHigh) begin
      if (hv[4]) begin
        end_tok  = 1'b1;
        e_status = StMalformed;
      end else begin
        st_next_o.high_nibble = hv[3:0];
        st_next_o.esc         = EscLow;
      end
    end else if (st_i.esc == EscLow) begin
      if (hv[4]) begin
        end_tok  = 1'b1;
        e_status = StMalformed;
      end else begin
        res_valid_o              = 1'b1;
        res_o.char_valid         = 1'b1;
        res_o.out_char           = {st_i.high_nibble, hv[3:0]};
        st_next_o.esc            = EscNone;
        st_next_o.high_nibble    = 4'd0;
        st_next_o.length_count   = len_inc;
      end
    end else if (item_i.mode == ModeSkip) begin
      if (!cls[2]) begin
        end_tok = 1'b1;
        e_len   = '0;
        e_again = cls[3];
      end
    end else if (cls[item_i.mode]) begin
      if (b == CharPercent) begin
        st_next_o.esc = EscHigh;
      end else begin
        res_valid_o            = 1'b1;
        res_o.char_valid       = 1'b1;
        res_o.out_char         = b;
        st_next_o.length_count = len_inc;
      end
    end else begin
      end_tok = 1'b1;
      case (b) inside
        CharNul, CharCr, CharLf, CharSpace: begin
          if (st_i.length_count == '0) begin
            e_status = StEmpty;
          end else begin
            e_again = 1'b1;
          end
        end
        CharQuery: begin
          e_status = (item_i.mode == ModePath) ? StOk : StMalformed;
        end
        CharEquals: begin
          e_status = (item_i.mode == ModeParam) ? StOk : StMalformed;
        end
        CharAmp: begin
          if (item_i.mode == ModePath) begin
            e_status = StMalformed;
          end else begin
            e_again = (item_i.mode == ModeParam);
          end
        end
        default: begin
          e_status = StMalformed;
        end
      endcase
    end

    if (end_tok) begin
      res_valid_o        = 1'b1;
      res_o.token_end    = 1'b1;
      res_o.status       = e_status;
      res_o.token_length = TokLenW'(e_len);
      res_o.reconsume    = e_again;
      st_next_o          = '0;
    end
  end

endmodule

// ----- rtl/core/url_query_token_scanner_top.sv -----
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i/in_stall_o   in_data_i  (in_byte, mode)
// out      output     out_valid_o/out_stall_i out_data_o (char_valid .. reconsume)
//
// One transaction enters the input register per cycle while in_stall_o is low; from
// there it is decoded by the class lookup and escape logic and written to the result register.
// Throughput is one byte per cycle while the output does not stall.
// Reset clears the escape state, the token length and both valid flags.
// A stall on the output holds a byte that yields a result in the input register;
// a byte that yields no result moves on regardless.
module url_query_token_scanner_top import uqts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic   s1_valid_q, s1_valid_d;
  in_t    s1_data_q;
  state_t st_q, st_d;
  logic   out_valid_q, out_valid_d;
  out_t   out_data_q;
  logic   res_valid;
  out_t   res;
  logic   out_blocked;
  logic   adv;
  logic   in_acc;

  uqts_step u_step (
    .st_i        (st_q),
    .item_i      (s1_data_q),
    .res_valid_o (res_valid),
    .res_o       (res),
    .st_next_o   (st_d)
  );

  assign out_blocked = out_valid_q && out_stall_i;
  assign adv         = s1_valid_q && (!res_valid || !out_blocked);
  assign in_stall_o  = s1_valid_q && !adv;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign s1_valid_d  = in_acc || (s1_valid_q && !adv);
  assign out_valid_d = (adv && res_valid) || out_blocked;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (adv) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_data_q <= in_data_i;
    end
    if (adv && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && res_valid && res.token_end |=> st_q.length_count == '0 && st_q.esc == EscNone)
    else $error("Token end did not clear the scanner state.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.token_end |-> !out_data_o.char_valid &&
      (out_data_o.status == StOk || !out_data_o.reconsume))
    else $error("Token end result carries a byte or an illegal reconsume.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.token_end && out_data_o.status == StEmpty |->
      out_data_o.token_length == '0)
    else $error("Empty token reported a nonzero length.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && st_q.esc != EscNone && s1_data_q.in_byte == CharPercent |-> res.token_end)
    else $error("Percent sign accepted as an escape digit.");

endmodule
